// ----- rtl/tfns_pkg.sv -----
// shared types, constants and the case-folding function of the fuzzy name scorer
package tfns_pkg;

   localparam int CHAR_W  = 8;
   localparam int SCORE_W = 10;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int QLEN_W = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_A      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_LENGTH = 3'd4;

   // match kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUBSEQ = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUBSTR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PREFIX = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXACT  = 3'd4;

   // scores
   localparam logic [SCORE_W-1:0] SCORE_EXACT  = 10'd1000;
   localparam logic [SCORE_W-1:0] SCORE_PREFIX = 10'd500;
   localparam logic [SCORE_W-1:0] SCORE_SUBSTR = 10'd200;
   localparam logic [SCORE_W-1:0] SCORE_NONE   = 10'd0;

   typedef struct packed {
      logic              fire;
      logic [CHAR_W-1:0] name_byte;
      logic              last;
   } step_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [KIND_W-1:0]  kind;
   } result_type;

   // ascii upper case to lower case, other bytes unchanged
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ----- rtl/tfns_csr.sv -----
// query register file: folded query characters and clamped query length
module tfns_csr #(
   parameter int QUERY_MAX = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [tfns_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tfns_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic [QUERY_MAX-1:0][tfns_pkg::CHAR_W-1:0] query_chars,
   output logic [$clog2(QUERY_MAX+1)-1:0]          active_len
);

   localparam int LEN_W = $clog2(QUERY_MAX + 1);

   logic [QUERY_MAX-1:0][tfns_pkg::CHAR_W-1:0] query_ff, query_in;
   logic [tfns_pkg::QLEN_W-1:0]                 length_ff, length_in;

   always_comb begin
      query_in  = query_ff;
      length_in = length_ff;
      if (csr_write) begin
         for (int i = 0; i < QUERY_MAX; i++) begin
            if (csr_index == tfns_pkg::REG_QUERY_A + tfns_pkg::CSR_IDX_W'(i >> 3)) begin
               query_in[i] = tfns_pkg::fold_char(csr_data[8*(i & 7) +: 8]);
            end
         end
         if (csr_index == tfns_pkg::REG_QUERY_LENGTH) begin
            length_in = csr_data[tfns_pkg::QLEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff  <= '0;
         length_ff <= '0;
      end else begin
         query_ff  <= query_in;
         length_ff <= length_in;
      end
   end

   assign query_chars = query_ff;

   // lengths beyond the storage clamp to it
   assign active_len = (length_ff > tfns_pkg::QLEN_W'(QUERY_MAX)) ?
                       LEN_W'(QUERY_MAX) : LEN_W'(length_ff);

endmodule

// ----- rtl/tfns_match.sv -----
// per-name match state: shift-and window, prefix flag, length and subsequence index
module tfns_match #(
   parameter int QUERY_MAX = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  tfns_pkg::step_type                          step,
   input  logic [QUERY_MAX-1:0][tfns_pkg::CHAR_W-1:0]  query_chars,
   input  logic [$clog2(QUERY_MAX+1)-1:0]              active_len,
   output tfns_pkg::result_type                        result
);

   localparam int IDX_W = $clog2(QUERY_MAX);
   localparam int LEN_W = $clog2(QUERY_MAX + 1);
   localparam int CNT_W = $clog2(QUERY_MAX + 2);

   logic [QUERY_MAX-1:0] hits_ff, hits_in, hits_next;
   logic                 substr_ff, substr_in, substr_next;
   logic                 prefix_ff, prefix_in, prefix_next;
   logic [CNT_W-1:0]     count_ff, count_in, count_next;
   logic [LEN_W-1:0]     subseq_ff, subseq_in, subseq_next;

   logic [tfns_pkg::CHAR_W-1:0] name_char;
   logic [QUERY_MAX-1:0]        eq;
   logic [IDX_W-1:0]            tail_idx;
   logic [CNT_W-1:0]            len_cnt;
   logic [tfns_pkg::SCORE_W-1:0] subseq_score;

   assign name_char = tfns_pkg::fold_char(step.name_byte);

   // compare the byte with every active query character
   always_comb begin
      for (int i = 0; i < QUERY_MAX; i++) begin
         eq[i] = (LEN_W'(i) < active_len) && (query_chars[i] == name_char);
      end
   end

   assign tail_idx = IDX_W'(active_len - 1'b1);
   assign len_cnt  = CNT_W'(active_len);

   always_comb begin
      hits_next   = {hits_ff[QUERY_MAX-2:0], 1'b1} & eq;
      substr_next = substr_ff | ((active_len != '0) && hits_next[tail_idx]);

      prefix_next = prefix_ff;
      if ((count_ff < len_cnt) && !eq[count_ff[IDX_W-1:0]]) begin
         prefix_next = 1'b0;
      end

      subseq_next = subseq_ff;
      if ((subseq_ff < active_len) && eq[subseq_ff[IDX_W-1:0]]) begin
         subseq_next = subseq_ff + 1'b1;
      end

      count_next = count_ff;
      if (count_ff < CNT_W'(QUERY_MAX + 1)) begin
         count_next = count_ff + 1'b1;
      end
   end

   // ten per query character
   assign subseq_score = tfns_pkg::SCORE_W'({active_len, 3'b000}) +
                         tfns_pkg::SCORE_W'({active_len, 1'b0});

   always_comb begin
      result.score = tfns_pkg::SCORE_NONE;
      result.kind  = tfns_pkg::KIND_NONE;
      if (active_len != '0) begin
         priority if (prefix_next && count_next == len_cnt) begin
            result.score = tfns_pkg::SCORE_EXACT;
            result.kind  = tfns_pkg::KIND_EXACT;
         end else if (prefix_next && count_next > len_cnt) begin
            result.score = tfns_pkg::SCORE_PREFIX;
            result.kind  = tfns_pkg::KIND_PREFIX;
         end else if (substr_next) begin
            result.score = tfns_pkg::SCORE_SUBSTR;
            result.kind  = tfns_pkg::KIND_SUBSTR;
         end else if (subseq_next == active_len) begin
            result.score = subseq_score;
            result.kind  = tfns_pkg::KIND_SUBSEQ;
         end else begin
            result.score = tfns_pkg::SCORE_NONE;
            result.kind  = tfns_pkg::KIND_NONE;
         end
      end
   end

   // last byte returns the state to its start values
   always_comb begin
      hits_in   = hits_ff;
      substr_in = substr_ff;
      prefix_in = prefix_ff;
      count_in  = count_ff;
      subseq_in = subseq_ff;
      if (step.fire) begin
         if (step.last) begin
            hits_in   = '0;
            substr_in = 1'b0;
            prefix_in = 1'b1;
            count_in  = '0;
            subseq_in = '0;
         end else begin
            hits_in   = hits_next;
            substr_in = substr_next;
            prefix_in = prefix_next;
            count_in  = count_next;
            subseq_in = subseq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         substr_ff <= 1'b0;
         prefix_ff <= 1'b1;
         count_ff  <= '0;
         subseq_ff <= '0;
      end else begin
         hits_ff   <= hits_in;
         substr_ff <= substr_in;
         prefix_ff <= prefix_in;
         count_ff  <= count_in;
         subseq_ff <= subseq_in;
      end
   end

endmodule

// ----- rtl/tiered_fuzzy_name_scorer_core.sv -----
// top level of the tiered fuzzy name scorer
// order: a name byte is scored by the match stage from the input register, and a final byte's score is loaded
//   into the result register that drives rsp_valid; throughput: one name byte per cycle,
//   set by the single match stage and result register; a final byte waits while that is full and not being emptied
// reset: synchronous, clears query registers, per-name state and both valid flags
module tiered_fuzzy_name_scorer_core #(
   parameter int QUERY_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // name byte channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tfns_pkg::CHAR_W-1:0]         req_name_byte,
   input  logic                                req_name_end,
   // score channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tfns_pkg::SCORE_W-1:0]        rsp_score,
   output logic [tfns_pkg::KIND_W-1:0]         rsp_match_kind,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tfns_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tfns_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int LEN_W = $clog2(QUERY_MAX + 1);

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [tfns_pkg::CHAR_W-1:0] in_byte_ff, in_byte_in;
   logic                        in_end_ff, in_end_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   tfns_pkg::result_type        out_ff, out_in;

   logic                        step_fire;
   tfns_pkg::step_type          step;
   tfns_pkg::result_type        result;

   logic [QUERY_MAX-1:0][tfns_pkg::CHAR_W-1:0] query_chars;
   logic [LEN_W-1:0]                           active_len;

   // registers are always writable
   assign csr_ready = 1'b1;

   tfns_csr #(
      .QUERY_MAX (QUERY_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .query_chars (query_chars),
      .active_len  (active_len)
   );

   // a byte that is not the last never needs the result register, so it always moves on;
   // a final byte moves on once the result register is empty or being emptied
   assign step_fire = in_valid_ff && (!in_end_ff || !out_valid_ff || rsp_ready);

   // the input register takes a new byte whenever its current one moves on
   assign req_ready = !in_valid_ff || step_fire;

   always_comb begin
      step.fire      = step_fire;
      step.name_byte = in_byte_ff;
      step.last      = in_end_ff;
   end

   tfns_match #(
      .QUERY_MAX (QUERY_MAX)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .query_chars (query_chars),
      .active_len  (active_len),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_name_byte;
         in_end_in   = req_name_end;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step_fire && in_end_ff) begin
         // load a fresh score, either into an empty register or over one being taken
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      out_ff     <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_score      = out_ff.score;
   assign rsp_match_kind = out_ff.kind;

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the tiered fuzzy name scorer: directed names, then random phases
`timescale 1ns / 1ps

module tb_top;

   localparam int QUERY_MAX     = 32;
   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 550;
   localparam int PHASE_ITEMS   = 70;
   // a name byte passes the core's input register and, if final, its result register; these settle the core
   localparam int SETTLE_CYCLES = 8;
   localparam int PRESSURE_AT   = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [tfns_pkg::SCORE_W-1:0] SCORE_PER_CHAR = 10'd10;

   typedef struct packed {
      logic [tfns_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } name_char_type;

   // shapes of random names, most of them built from the query itself
   typedef enum logic [3:0] {
      SHAPE_EXACT, SHAPE_PREFIX, SHAPE_SUBSTR, SHAPE_SUBSEQ, SHAPE_OVERLAP,
      SHAPE_LONG, SHAPE_NEAR, SHAPE_JUNK, SHAPE_BYTES
   } name_shape_type;

   // receiver stall patterns
   typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_MOSTLY} ready_mode_type;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_ready;
   logic [tfns_pkg::CHAR_W-1:0]     req_name_byte  = '0;
   logic                            req_name_end   = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready      = 1'b0;
   logic [tfns_pkg::SCORE_W-1:0]    rsp_score;
   logic [tfns_pkg::KIND_W-1:0]     rsp_match_kind;
   logic                            csr_valid      = 1'b0;
   logic                            csr_ready;
   logic [tfns_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [tfns_pkg::CSR_DATA_W-1:0] csr_data       = '0;

   tiered_fuzzy_name_scorer_core #(
      .QUERY_MAX(QUERY_MAX)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_name_byte  (req_name_byte),
      .req_name_end   (req_name_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_score      (rsp_score),
      .rsp_match_kind (rsp_match_kind),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // shadow of the query registers and the per-name matching state
   // ---------------------------------------------------------------------------------------
   logic [8*QUERY_MAX-1:0]        query_text       = '0;
   logic [tfns_pkg::QLEN_W-1:0]   query_len_reg    = '0;
   logic [QUERY_MAX-1:0]          win_hits         = '0;
   logic                          whole_query_seen = 1'b0;
   logic                          prefix_ok        = 1'b1;
   logic [tfns_pkg::QLEN_W-1:0]   chars_seen       = '0;
   logic [tfns_pkg::QLEN_W-1:0]   subseq_idx       = '0;

   tfns_pkg::result_type expected_scores[$];
   name_char_type        pending_bytes[$];
   int                   bytes_unsent = 0;
   int                   results_seen = 0;
   int                   fail_count   = 0;

   function automatic logic [tfns_pkg::CHAR_W-1:0] lower_char(
      input logic [tfns_pkg::CHAR_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // query length in use, anything beyond the array is clipped
   function automatic int used_length();
      return (query_len_reg > QUERY_MAX) ? QUERY_MAX : int'(query_len_reg);
   endfunction

   function automatic logic [tfns_pkg::CHAR_W-1:0] query_char(input int i);
      return lower_char(query_text[8*i +: 8]);
   endfunction

   // one name byte through the matcher; the final byte yields the expected score
   task automatic score_name_byte(input logic [tfns_pkg::CHAR_W-1:0] raw, input logic last);
      int                          len;
      int                          i;
      logic [tfns_pkg::CHAR_W-1:0] c;
      logic [QUERY_MAX-1:0]        eq;
      tfns_pkg::result_type        res;
      len = used_length();
      c   = lower_char(raw);
      eq  = '0;
      for (i = 0; i < len; i++) begin
         if (query_char(i) == c) begin
            eq[i] = 1'b1;
         end
      end
      // shift-and: bit i holds when the last i+1 bytes equal query chars 0..i
      win_hits = {win_hits[QUERY_MAX-2:0], 1'b1} & eq;
      if (len > 0 && win_hits[len-1]) begin
         whole_query_seen = 1'b1;
      end
      if (chars_seen < len && query_char(chars_seen) != c) begin
         prefix_ok = 1'b0;
      end
      if (subseq_idx < len && query_char(subseq_idx) == c) begin
         subseq_idx++;
      end
      if (chars_seen < QUERY_MAX + 1) begin
         chars_seen++;
      end
      if (last) begin
         res.score = tfns_pkg::SCORE_NONE;
         res.kind  = tfns_pkg::KIND_NONE;
         if (len > 0) begin
            if (prefix_ok && chars_seen == len) begin
               res.score = tfns_pkg::SCORE_EXACT;
               res.kind  = tfns_pkg::KIND_EXACT;
            end else if (prefix_ok && chars_seen > len) begin
               res.score = tfns_pkg::SCORE_PREFIX;
               res.kind  = tfns_pkg::KIND_PREFIX;
            end else if (whole_query_seen) begin
               res.score = tfns_pkg::SCORE_SUBSTR;
               res.kind  = tfns_pkg::KIND_SUBSTR;
            end else if (subseq_idx == len) begin
               res.score = SCORE_PER_CHAR * tfns_pkg::SCORE_W'(len);
               res.kind  = tfns_pkg::KIND_SUBSEQ;
            end
         end
         expected_scores.insert(expected_scores.size(), res);
         win_hits         = '0;
         whole_query_seen = 1'b0;
         prefix_ok        = 1'b1;
         chars_seen       = '0;
         subseq_idx       = '0;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // name byte driver: bursts of random length with random gaps, sometimes none at all
   // ---------------------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : byte_driver
      name_char_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // a transfer at this edge goes straight into the predictor
         if (req_valid && req_ready) begin
            score_name_byte(req_name_byte, req_name_end);
            bytes_unsent--;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && gap_left == 0) begin
               nxt = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_name_byte <= nxt.ch;
               req_name_end  <= nxt.last;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
               if (gap_left != 0) begin
                  gap_left--;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // score receiver: changing stall patterns plus one long hold-off so the core backs up
   // ---------------------------------------------------------------------------------------
   ready_mode_type ready_mode    = RDY_ALWAYS;
   int             stall_tick    = 0;
   int             hold_left     = 0;
   logic           pressure_done = 1'b0;

   always @(posedge clock) begin : score_stall
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_tick++;
         if (!pressure_done && results_seen >= PRESSURE_AT) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               RDY_ALWAYS:   rsp_ready <= 1'b1;
               RDY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RDY_PERIODIC: rsp_ready <= (stall_tick % 7) >= 3;
               default:      rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
            if (stall_tick % 50 == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // score monitor: every transfer against the oldest expectation
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : score_monitor
      tfns_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_scores.size() == 0) begin
            $error("unexpected score transfer: score %0d match_kind %0d",
                   rsp_score, rsp_match_kind);
            fail_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_score !== want.score) begin
               $error("score: expected %0d, actual %0d", want.score, rsp_score);
               fail_count++;
            end
            if (rsp_match_kind !== want.kind) begin
               $error("match_kind: expected %0d, actual %0d", want.kind, rsp_match_kind);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   int unsigned cycle_count = 0;

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic void push_char(input logic [tfns_pkg::CHAR_W-1:0] ch, input logic last);
      name_char_type item;
      item.ch   = ch;
      item.last = last;
      pending_bytes.insert(pending_bytes.size(), item);
      bytes_unsent++;
   endfunction

   function automatic void push_text(input string s, input logic close);
      int i;
      for (i = 0; i < s.len(); i++) begin
         push_char(s[i], close && (i == s.len() - 1));
      end
   endfunction

   function automatic logic [8*QUERY_MAX-1:0] pack_text(input string s);
      logic [8*QUERY_MAX-1:0] t;
      int                     i;
      t = '0;
      for (i = 0; i < s.len(); i++) begin
         t[8*i +: 8] = s[i];
      end
      return t;
   endfunction

   // flips the case of letters now and then, folding must hide it
   function automatic logic [tfns_pkg::CHAR_W-1:0] vary_case(
      input logic [tfns_pkg::CHAR_W-1:0] c);
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
          && $urandom_range(0, 1) == 1) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [tfns_pkg::CHAR_W-1:0] rand_query_char();
      logic [tfns_pkg::CHAR_W-1:0] near_fold[8];
      near_fold = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return tfns_pkg::CHAR_W'(8'h61 + $urandom_range(0, 5));
         4:          return tfns_pkg::CHAR_W'(8'h41 + $urandom_range(0, 5));
         5:          return tfns_pkg::CHAR_W'(8'h2D + $urandom_range(0, 12));
         6:          return tfns_pkg::CHAR_W'($urandom_range(0, 255));
         default:    return near_fold[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic logic [8*QUERY_MAX-1:0] random_query();
      logic [8*QUERY_MAX-1:0] t;
      int                     i;
      for (i = 0; i < QUERY_MAX; i++) begin
         t[8*i +: 8] = rand_query_char();
      end
      return t;
   endfunction

   // filler byte: often a query char, so matches start and break off
   function automatic logic [tfns_pkg::CHAR_W-1:0] junk_char();
      int len;
      int pos;
      len = used_length();
      case ($urandom_range(0, 3))
         0: begin
            if (len == 0) begin
               return 8'h2E;
            end
            pos = $urandom_range(0, len - 1);
            return vary_case(query_text[8*pos +: 8]);
         end
         1:       return tfns_pkg::CHAR_W'(8'h61 + $urandom_range(0, 7));
         2:       return tfns_pkg::CHAR_W'($urandom_range(0, 255));
         default: return tfns_pkg::CHAR_W'(8'h2E + $urandom_range(0, 11));
      endcase
   endfunction

   // queues one complete random name, returns its length
   function automatic int queue_random_name();
      logic [tfns_pkg::CHAR_W-1:0] name_q[$];
      name_shape_type              shape;
      int                          len;
      int                          i;
      int                          n;
      int                          cut;
      len   = used_length();
      shape = name_shape_type'($urandom_range(0, 8));
      if (len == 0 && shape < SHAPE_JUNK) begin
         shape = SHAPE_JUNK;
      end
      case (shape)
         SHAPE_EXACT, SHAPE_PREFIX: begin
            for (i = 0; i < len; i++) begin
               name_q.insert(name_q.size(), vary_case(query_text[8*i +: 8]));
            end
            if (shape == SHAPE_PREFIX) begin
               n = $urandom_range(1, 8);
               repeat (n) name_q.insert(name_q.size(), junk_char());
            end
         end
         SHAPE_SUBSTR: begin
            n = $urandom_range(1, 5);
            repeat (n) name_q.insert(name_q.size(), junk_char());
            for (i = 0; i < len; i++) begin
               name_q.insert(name_q.size(), vary_case(query_text[8*i +: 8]));
            end
            n = $urandom_range(0, 5);
            repeat (n) name_q.insert(name_q.size(), junk_char());
         end
         SHAPE_SUBSEQ: begin
            for (i = 0; i < len; i++) begin
               name_q.insert(name_q.size(), vary_case(query_text[8*i +: 8]));
               if ($urandom_range(0, 1) == 1) begin
                  n = $urandom_range(1, 3);
                  repeat (n) name_q.insert(name_q.size(), junk_char());
               end
            end
         end
         SHAPE_OVERLAP: begin
            // a false start of the query right before the real thing
            cut = $urandom_range(0, len - 1);
            for (i = 0; i <= cut; i++) begin
               name_q.insert(name_q.size(), query_text[8*i +: 8]);
            end
            for (i = 0; i < len; i++) begin
               name_q.insert(name_q.size(), query_text[8*i +: 8]);
            end
            n = $urandom_range(0, 2);
            repeat (n) name_q.insert(name_q.size(), junk_char());
         end
         SHAPE_LONG: begin
            // around and past the saturation point of the name length
            n = $urandom_range(30, 40);
            for (i = 0; i < n; i++) begin
               name_q.insert(name_q.size(), vary_case(query_text[8*(i % len) +: 8]));
            end
         end
         SHAPE_NEAR: begin
            // one query char dropped or replaced
            cut = $urandom_range(0, len - 1);
            for (i = 0; i < len; i++) begin
               if (i != cut) begin
                  name_q.insert(name_q.size(), query_text[8*i +: 8]);
               end else if ($urandom_range(0, 1) == 1) begin
                  name_q.insert(name_q.size(), junk_char());
               end
            end
         end
         SHAPE_JUNK: begin
            n = $urandom_range(1, 12);
            repeat (n) name_q.insert(name_q.size(), junk_char());
         end
         default: begin
            n = $urandom_range(1, 6);
            repeat (n) name_q.insert(name_q.size(), tfns_pkg::CHAR_W'($urandom_range(0, 255)));
         end
      endcase
      if (name_q.size() == 0) begin
         name_q.insert(name_q.size(), junk_char());
      end
      foreach (name_q[k]) begin
         push_char(name_q[k], k == name_q.size() - 1);
      end
      return name_q.size();
   endfunction

   // register write, shadow updated at the transfer
   task automatic write_reg(input logic [tfns_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [tfns_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tfns_pkg::REG_QUERY_LENGTH) begin
         query_len_reg = val[tfns_pkg::QLEN_W-1:0];
      end else begin
         query_text[tfns_pkg::CSR_DATA_W*idx +: tfns_pkg::CSR_DATA_W] = val;
      end
   endtask

   task automatic write_query(input logic [8*QUERY_MAX-1:0]      t,
                              input logic [tfns_pkg::QLEN_W-1:0] len);
      int w;
      for (w = 0; w < 4; w++) begin
         write_reg(tfns_pkg::REG_QUERY_A + tfns_pkg::CSR_IDX_W'(w),
                   t[tfns_pkg::CSR_DATA_W*w +: tfns_pkg::CSR_DATA_W]);
      end
      write_reg(tfns_pkg::REG_QUERY_LENGTH, tfns_pkg::CSR_DATA_W'(len));
   endtask

   // every byte sent and every score back, then the pipeline drains
   task automatic wait_idle();
      do @(posedge clock); while (bytes_unsent != 0 || expected_scores.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      logic [8*QUERY_MAX-1:0]      t;
      logic [tfns_pkg::QLEN_W-1:0] len_pick;
      logic [tfns_pkg::QLEN_W-1:0] extreme_lens[3];
      int                          random_items;
      int                          phase_items;
      int                          phase_no;
      int                          r;
      extreme_lens = '{6'd0, 6'd32, 6'd63};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // mixed-case query against each tier
      write_query(pack_text("AbC"), 6'd3);
      push_text("abc", 1'b1);
      push_text("ABcd", 1'b1);
      push_text("xAbCy", 1'b1);
      push_text("aXbYc", 1'b1);
      // length rewritten in the middle of a name, its state carries on
      push_text("ab", 1'b0);
      wait_idle();
      write_reg(tfns_pkg::REG_QUERY_LENGTH, tfns_pkg::CSR_DATA_W'(2));
      push_text("c", 1'b1);
      // one-byte names at both ends of the byte range
      push_char(8'hFF, 1'b1);
      push_char(8'h00, 1'b1);
      wait_idle();

      // non-ascii byte and the neighbours of the upper case range stay unfolded
      t = '0;
      t[31:0] = {8'h5B, 8'h5A, 8'h40, 8'hC1};
      write_query(t, 6'd4);
      push_char(8'hC1, 1'b0);
      push_char(8'h40, 1'b0);
      push_char(8'h7A, 1'b0);
      push_char(8'h5B, 1'b1);
      push_char(8'hE1, 1'b0);
      push_char(8'h40, 1'b0);
      push_char(8'h5A, 1'b1);
      wait_idle();

      // empty query scores nothing
      write_reg(tfns_pkg::REG_QUERY_LENGTH, tfns_pkg::CSR_DATA_W'(0));
      push_char(8'hC1, 1'b1);
      wait_idle();

      // random phases, each with a fresh query
      random_items = 0;
      phase_no     = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase_no)
            0: begin
               t        = '1;
               len_pick = 6'd32;
            end
            1: begin
               t        = '0;
               len_pick = 6'd63;
            end
            2: begin
               t        = random_query();
               len_pick = 6'd1;
            end
            default: begin
               t = random_query();
               r = $urandom_range(0, 9);
               if (r < 7) begin
                  len_pick = tfns_pkg::QLEN_W'($urandom_range(1, 8));
               end else if (r < 9) begin
                  len_pick = tfns_pkg::QLEN_W'($urandom_range(9, 31));
               end else begin
                  len_pick = extreme_lens[$urandom_range(0, 2)];
               end
            end
         endcase
         write_query(t, len_pick);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            phase_items += queue_random_name();
         end
         // sometimes leave a name open across the next register writes
         if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(1, 3);
            repeat (r) push_char(junk_char(), 1'b0);
            phase_items += r;
         end
         random_items += phase_items;
         wait_idle();
         phase_no++;
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tfns_pkg.sv
rtl/tfns_csr.sv
rtl/tfns_match.sv
rtl/tiered_fuzzy_name_scorer_core.sv
sim/tb_top.sv
